// ===== hdl/irtwa_pkg.sv =====
// Shared widths, register indexes, constants and lane control types for the IR window averager.
package irtwa_pkg;

    // Window length limit and register reset value
    localparam int unsigned MAX_WINDOW_DEF = 256;
    localparam int unsigned CFG_W          = 9;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd10;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NORMAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ALERT  = 1'b1;

    // Sample word layout
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned RAW_W     = 15;
    localparam int unsigned ERR_BIT   = 15;

    // Result layout
    localparam int unsigned MEAN_W    = 17;
    localparam int unsigned QUOT_W    = 16;
    localparam int unsigned CNT_OUT_W = 9;
    localparam logic signed [MEAN_W-1:0] KELVIN_OFFSET_CENTI = 17'sd27315;

    // Stream widths
    localparam int unsigned S_TDATA_W = 2 * WORD_W;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_FIELD_W = 2 * MEAN_W + 2 * CNT_OUT_W;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Per-beat control from the sequencer to each lane
    typedef struct packed {
        logic clear;   // first beat of a window: restart the sum
        logic add;     // beat carries a valid pair
        logic start;   // window closed: begin the division
    } t_lane_ctrl;

endpackage

// ===== hdl/irtwa_lane.sv =====
// One averaging lane: raw-value accumulator and a restoring divider that yields the centi-degree mean.
module irtwa_lane #(
    parameter int unsigned MAX_WINDOW = irtwa_pkg::MAX_WINDOW_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  irtwa_pkg::t_lane_ctrl                   i_ctrl,
    input  logic [irtwa_pkg::RAW_W-1:0]             i_raw,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]         i_count,
    output logic                                    o_busy,
    output logic signed [irtwa_pkg::MEAN_W-1:0]     o_mean
);
    import irtwa_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_W  = RAW_W + CNT_W;
    localparam int unsigned NUM_W  = SUM_W + 3;
    localparam int unsigned DIV_W  = CNT_W + 1;
    localparam int unsigned REM_W  = CNT_W + 2;
    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [NUM_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_zero;
    logic [REM_W-1:0]  rem_sh;
    logic              q_bit;
    logic [QUOT_W-1:0] quot;

    // Accumulate raw values of valid pairs
    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.clear) begin
            n_sum = i_ctrl.add ? SUM_W'(i_raw) : '0;
        end else if (i_ctrl.add) begin
            n_sum = r_sum + SUM_W'(i_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // One quotient bit per cycle: shift in the next numerator bit, subtract if it fits
    assign rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign q_bit  = (rem_sh >= REM_W'(r_div));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_ctrl.start) begin
            r_step <= STEP_W'(NUM_W);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    // Numerator 4*sum + n over divisor 2*n rounds 2*sum/n to nearest
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_num  <= {r_sum, 2'b00} + NUM_W'(i_count);
            r_rem  <= '0;
            r_div  <= {i_count, 1'b0};
            r_zero <= (i_count == '0);
        end else if (r_step != '0) begin
            r_num  <= {r_num[NUM_W-2:0], q_bit};
            r_rem  <= q_bit ? (rem_sh - REM_W'(r_div)) : rem_sh;
        end
    end

    // Shift the kelvin scale to Celsius; no valid pair gives zero
    assign quot   = r_num[QUOT_W-1:0];
    assign o_busy = (r_step != '0);
    assign o_mean = r_zero ? '0 : (signed'({1'b0, quot}) - KELVIN_OFFSET_CENTI);

endmodule

// ===== hdl/irtwa_merge.sv =====
// Merge stage: packs both lane means and the window counts into the registered result beat.
module irtwa_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic signed [irtwa_pkg::MEAN_W-1:0]     i_object_mean,
    input  logic signed [irtwa_pkg::MEAN_W-1:0]     i_ambient_mean,
    input  logic [irtwa_pkg::CNT_OUT_W-1:0]         i_valid_samples,
    input  logic [irtwa_pkg::CNT_OUT_W-1:0]         i_total_samples,
    output logic                                    o_free,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [irtwa_pkg::M_TDATA_W-1:0]         m_axis_tdata
);
    import irtwa_pkg::*;

    logic                 r_valid;
    logic [M_TDATA_W-1:0] r_data;

    // Slot is free when empty or being drained this cycle
    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= M_TDATA_W'({i_total_samples, i_valid_samples,
                                  i_ambient_mean, i_object_mean});
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

// ===== hdl/ir_temp_window_averager.sv =====
// Top level of the IR temperature window averager: sequencer, window registers and two lanes.
// Input beats are taken while the sequencer is in its run state. The beat that closes a
// window starts a restoring divider in the object and ambient lanes, one quotient bit per
// cycle over a numerator of $clog2(MAX_WINDOW+1)+18 bits, so the block then holds
// s_axis_tready low until both lanes are done and the output register is free to take the
// result beat, which is then loaded; only then may the next window begin. A window holds window_normal or
// window_alert samples, chosen by the mode bit of its first beat; zero counts as one and
// values above MAX_WINDOW saturate. Means are in 0.01 degrees Celsius and are zero when no
// sample pair in the window was valid. Register writes take effect at the next window start.
module ir_temp_window_averager #(
    parameter int unsigned MAX_WINDOW = irtwa_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [irtwa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irtwa_pkg::CFG_W-1:0]          i_cfg_data,
    // sample stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] object_word, [31:16] ambient_word
    input  logic [irtwa_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] object_read_ok, [1] ambient_read_ok, [2] mode
    input  logic [irtwa_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] object_mean_centi, [33:17] ambient_mean_centi,
    // [42:34] valid_samples, [51:43] total_samples, [55:52] zero
    output logic [irtwa_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import irtwa_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [CFG_W-1:0] r_window_normal;
    logic [CFG_W-1:0] r_window_alert;
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_position;
    logic [CNT_W-1:0] r_length;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_length;
    logic [CNT_W-1:0] new_length;
    logic [CNT_W-1:0] eff_length;
    logic [CNT_W:0]   pos_next;
    logic [CFG_W-1:0] sel_window;

    logic             accept;
    logic             first;
    logic             last;
    logic             pair_ok;
    logic             load;
    logic             merge_free;

    logic [WORD_W-1:0] object_word;
    logic [WORD_W-1:0] ambient_word;

    t_lane_ctrl        lane_ctrl;
    logic              obj_busy;
    logic              amb_busy;
    logic signed [MEAN_W-1:0] obj_mean;
    logic signed [MEAN_W-1:0] amb_mean;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_normal <= WINDOW_RESET;
            r_window_alert  <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_NORMAL: r_window_normal <= i_cfg_data;
                REG_WINDOW_ALERT:  r_window_alert  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input beat and qualify the pair
    assign object_word  = s_axis_tdata[WORD_W-1:0];
    assign ambient_word = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign pair_ok      = s_axis_tuser[0] && s_axis_tuser[1]
                          && !object_word[ERR_BIT] && !ambient_word[ERR_BIT];

    assign s_axis_tready = (r_state == ST_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign first         = (r_position == '0);

    // Pick and clamp the window length on the first beat
    assign sel_window = s_axis_tuser[2] ? r_window_alert : r_window_normal;
    always_comb begin
        if (sel_window == '0) begin
            new_length = CNT_W'(1);
        end else if (32'(sel_window) > 32'(MAX_WINDOW)) begin
            new_length = CNT_W'(MAX_WINDOW);
        end else begin
            new_length = CNT_W'(sel_window);
        end
    end

    assign eff_length = first ? new_length : r_length;
    assign n_length   = (accept && first) ? new_length : r_length;
    assign pos_next   = {1'b0, r_position} + 1'b1;
    assign last       = (pos_next >= {1'b0, eff_length});

    // Position, length and valid count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_length   <= '0;
            r_count    <= '0;
        end else if (accept) begin
            r_length   <= n_length;
            r_position <= last ? '0 : pos_next[CNT_W-1:0];
            if (first) begin
                r_count <= CNT_W'(pair_ok);
            end else if (pair_ok) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Sequencer: take beats, then run the lanes' divide, then hand off the result
    assign load = (r_state == ST_DIV) && !obj_busy && !amb_busy && merge_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN:   if (accept && last) n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (load) n_state = ST_RUN;
            default:  n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign lane_ctrl.clear = accept && first;
    assign lane_ctrl.add   = accept && pair_ok;
    assign lane_ctrl.start = (r_state == ST_START);

    // Object and ambient lanes run side by side
    irtwa_lane #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_lane_object (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_raw   (object_word[RAW_W-1:0]),
        .i_count (r_count),
        .o_busy  (obj_busy),
        .o_mean  (obj_mean)
    );

    irtwa_lane #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_lane_ambient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_raw   (ambient_word[RAW_W-1:0]),
        .i_count (r_count),
        .o_busy  (amb_busy),
        .o_mean  (amb_mean)
    );

    irtwa_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_object_mean   (obj_mean),
        .i_ambient_mean  (amb_mean),
        .i_valid_samples (CNT_OUT_W'(r_count)),
        .i_total_samples (CNT_OUT_W'(r_length)),
        .o_free          (merge_free),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );

endmodule
